// ===== rtl/lcd_mode_timing_controller_defines.svh =====
// Assertion macros shared by the LCD mode timing controller RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef LCD_MODE_TIMING_CONTROLLER_DEFINES_SVH
`define LCD_MODE_TIMING_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define LCDMT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LCDMT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lcdmt_pkg.sv =====
// Types, constants and helpers for the LCD mode timing controller.
// No dependencies; used by lcdmt_step and lcd_mode_timing_controller.
package lcdmt_pkg;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_CTRL = 2'd1;
	localparam logic [1:0] OP_STAT = 2'd2;
	localparam logic [1:0] OP_LYC  = 2'd3;

	localparam logic [1:0] MODE_HBLANK = 2'd0;
	localparam logic [1:0] MODE_VBLANK = 2'd1;
	localparam logic [1:0] MODE_OAM    = 2'd2;
	localparam logic [1:0] MODE_DRAW   = 2'd3;

	localparam logic [6:0] LAST_HBLANK_DOT = 7'd93;
	localparam logic [6:0] LAST_VBLANK_DOT = 7'd113;
	localparam logic [6:0] LAST_OAM_DOT    = 7'd19;
	localparam logic [6:0] VBLANK_IRQ_DOT  = 7'd4;
	localparam logic [6:0] FIRST_DRAW_DOT  = 7'd3;

	localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
	localparam logic [7:0] LAST_FRAME_LINE   = 8'd153;
	localparam logic [7:0] RESET_LINE        = 8'd143;
	localparam logic [7:0] LINE_PIXELS       = 8'd160;
	localparam logic [7:0] GROUP_PIXELS      = 8'd4;

	// status enable bit positions
	localparam int EN_HBLANK = 0;
	localparam int EN_VBLANK = 1;
	localparam int EN_OAM    = 2;
	localparam int EN_COINC  = 3;

	localparam int CTRL_ENABLE_BIT = 7;

	typedef enum logic [3:0] {
		ST_HBLANK = 4'b0001,
		ST_VBLANK = 4'b0010,
		ST_OAM    = 4'b0100,
		ST_DRAW   = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] line;
		logic       coincide;
		logic       vblank_irq;
		logic       stat_irq;
		logic       draw_strobe;
		logic [7:0] pixel_pos;
		logic       oam_locked;
		logic       vram_locked;
	} result_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] line;
		logic [6:0] dot;
		logic [7:0] pixel;
		logic [3:0] irq_en;
		logic       coinc;
		logic [7:0] lyc;
		logic       lcd_on;
		logic       oam_lock;
		logic       vram_lock;
	} timing_state_t;

	function automatic logic [1:0] mode_code(input mode_t m);
		logic [1:0] code;
		case (m)
			ST_HBLANK: code = MODE_HBLANK;
			ST_VBLANK: code = MODE_VBLANK;
			ST_OAM:    code = MODE_OAM;
			default:   code = MODE_DRAW;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/lcdmt_step.sv =====
// Next-state and result logic for one transfer of the LCD mode timing controller.
// Purely combinational; depends on lcdmt_pkg.
module lcdmt_step (
	input  lcdmt_pkg::timing_state_t cur,
	input  lcdmt_pkg::item_t         item,
	output lcdmt_pkg::timing_state_t nxt,
	output lcdmt_pkg::result_t       res
);

	logic       st_irq;
	logic       vbl_irq;
	logic       drew;
	logic [7:0] line_inc;
	logic [7:0] pix_inc;
	logic       lyc_eq;

	assign line_inc = cur.line + 8'd1;
	assign pix_inc  = cur.pixel + lcdmt_pkg::GROUP_PIXELS;
	assign lyc_eq   = (cur.line == item.data);

	always_comb begin
		nxt     = cur;
		st_irq  = 1'b0;
		vbl_irq = 1'b0;
		drew    = 1'b0;
		case (item.op)
			lcdmt_pkg::OP_TICK: begin
				if (!cur.lcd_on) begin
					nxt.mode      = lcdmt_pkg::ST_HBLANK;
					nxt.line      = '0;
					nxt.dot       = '0;
					nxt.pixel     = '0;
					nxt.oam_lock  = 1'b0;
					nxt.vram_lock = 1'b0;
				end else begin
					case (cur.mode)
						lcdmt_pkg::ST_HBLANK: begin
							if (cur.dot == lcdmt_pkg::LAST_HBLANK_DOT) begin
								nxt.dot   = '0;
								nxt.line  = line_inc;
								nxt.coinc = (line_inc == cur.lyc);
								if (nxt.coinc && cur.irq_en[lcdmt_pkg::EN_COINC])
									st_irq = 1'b1;
								if (line_inc >= lcdmt_pkg::FIRST_VBLANK_LINE) begin
									nxt.mode = lcdmt_pkg::ST_VBLANK;
									if (cur.irq_en[lcdmt_pkg::EN_VBLANK])
										st_irq = 1'b1;
								end else begin
									nxt.mode     = lcdmt_pkg::ST_OAM;
									nxt.oam_lock = 1'b1;
									if (cur.irq_en[lcdmt_pkg::EN_OAM])
										st_irq = 1'b1;
								end
							end
						end
						lcdmt_pkg::ST_VBLANK: begin
							vbl_irq = (cur.line == lcdmt_pkg::FIRST_VBLANK_LINE) &&
								(cur.dot == lcdmt_pkg::VBLANK_IRQ_DOT);
							if (cur.dot == lcdmt_pkg::LAST_VBLANK_DOT) begin
								nxt.dot = '0;
								if (cur.line >= lcdmt_pkg::LAST_FRAME_LINE) begin
									nxt.line     = '0;
									nxt.mode     = lcdmt_pkg::ST_OAM;
									nxt.oam_lock = 1'b1;
									if (cur.irq_en[lcdmt_pkg::EN_OAM])
										st_irq = 1'b1;
								end else begin
									nxt.line = line_inc;
								end
								nxt.coinc = (nxt.line == cur.lyc);
								if (nxt.coinc && cur.irq_en[lcdmt_pkg::EN_COINC])
									st_irq = 1'b1;
							end
						end
						lcdmt_pkg::ST_OAM: begin
							if (cur.dot == lcdmt_pkg::LAST_OAM_DOT) begin
								nxt.dot       = '0;
								nxt.pixel     = '0;
								nxt.vram_lock = 1'b1;
								nxt.mode      = lcdmt_pkg::ST_DRAW;
							end
						end
						default: begin
							if (cur.dot >= lcdmt_pkg::FIRST_DRAW_DOT) begin
								nxt.pixel = pix_inc;
								drew      = 1'b1;
							end
							if (nxt.pixel >= lcdmt_pkg::LINE_PIXELS) begin
								if (cur.irq_en[lcdmt_pkg::EN_HBLANK])
									st_irq = 1'b1;
								nxt.oam_lock  = 1'b0;
								nxt.vram_lock = 1'b0;
								nxt.mode      = lcdmt_pkg::ST_HBLANK;
							end
						end
					endcase
					nxt.dot = nxt.dot + 7'd1;
				end
			end
			lcdmt_pkg::OP_CTRL: begin
				nxt.lcd_on = item.data[lcdmt_pkg::CTRL_ENABLE_BIT];
			end
			lcdmt_pkg::OP_STAT: begin
				nxt.irq_en = item.data[6:3];
			end
			default: begin
				nxt.lyc   = item.data;
				nxt.coinc = lyc_eq;
				st_irq    = lyc_eq && cur.irq_en[lcdmt_pkg::EN_COINC];
			end
		endcase
	end

	always_comb begin
		res.mode        = lcdmt_pkg::mode_code(nxt.mode);
		res.line        = nxt.line;
		res.coincide    = nxt.coinc;
		res.vblank_irq  = vbl_irq;
		res.stat_irq    = st_irq;
		res.draw_strobe = drew;
		res.pixel_pos   = nxt.pixel;
		res.oam_locked  = nxt.oam_lock;
		res.vram_locked = nxt.vram_lock;
	end

endmodule

// ===== rtl/lcd_mode_timing_controller.sv =====
// LCD mode timing controller: one tick or register write per transfer, one result each.
// Takes one item per clock while the output is not stalled. An accepted item is held in
// an input register; the timing state and result register update from it together when
// it advances: when the output register is empty or its result is taken. Sustained rate
// is one item per cycle when not stalled, set by the single-pass update of the timing
// state; item_ready follows result_ready combinationally while an item and a result wait.
// Depends on lcdmt_pkg, lcdmt_step and lcd_mode_timing_controller_defines.svh.
`include "lcd_mode_timing_controller_defines.svh"

module lcd_mode_timing_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  lcdmt_pkg::item_t    item,
	output logic                result_valid,
	input  logic                result_ready,
	output lcdmt_pkg::result_t  result
);

	lcdmt_pkg::item_t         item_s1;
	logic                     valid_s1;
	lcdmt_pkg::timing_state_t state_q;
	lcdmt_pkg::timing_state_t state_nxt;
	lcdmt_pkg::result_t       res_nxt;
	lcdmt_pkg::result_t       result_s2;
	logic                     valid_s2;
	logic                     adv;

	assign adv        = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	lcdmt_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode      <= lcdmt_pkg::ST_VBLANK;
			state_q.line      <= lcdmt_pkg::RESET_LINE;
			state_q.dot       <= '0;
			state_q.pixel     <= '0;
			state_q.irq_en    <= '0;
			state_q.coinc     <= 1'b0;
			state_q.lyc       <= '0;
			state_q.lcd_on    <= 1'b1;
			state_q.oam_lock  <= 1'b0;
			state_q.vram_lock <= 1'b0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= res_nxt;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	`LCDMT_ASSERT_NXT(a_state_hold, !adv, $stable(state_q), "timing state moved without a transfer")
	`LCDMT_ASSERT_IMP(a_vram_in_draw, valid_s2 && result_s2.vram_locked,
		result_s2.mode == lcdmt_pkg::MODE_DRAW, "vram locked outside drawing")
	`LCDMT_ASSERT_IMP(a_vram_implies_oam, valid_s2 && result_s2.vram_locked,
		result_s2.oam_locked, "vram locked while oam unlocked")
	`LCDMT_ASSERT_IMP(a_vblank_irq_line, valid_s2 && result_s2.vblank_irq,
		result_s2.line == lcdmt_pkg::FIRST_VBLANK_LINE &&
		result_s2.mode == lcdmt_pkg::MODE_VBLANK, "vblank request off first vblank line")

endmodule
